[hdl/hdlctx_pkg.sv]
// Shared types and constants for the HDLC transmitter (stuffing, NRZI, FCS).
package hdlctx_pkg;

    localparam int CrcWidth = 16;
    localparam int ByteWidth = 8;
    localparam int RunWidth = 3;
    localparam int CountWidth = 5;

    localparam logic [ByteWidth-1:0] FLAG_BYTE = 8'h7E;
    localparam logic [CrcWidth-1:0] CRC_POLY = 16'h8408;
    localparam logic [CrcWidth-1:0] CRC_INIT_RESET = 16'hFFFF;
    localparam logic [RunWidth-1:0] STUFF_RUN = 3'd5;

    localparam logic [CountWidth-1:0] BYTE_BITS = 5'd8;
    localparam logic [CountWidth-1:0] FCS_BITS = 5'd16;

    // Request codes
    localparam logic [1:0] REQ_FLAG = 2'd0;
    localparam logic [1:0] REQ_DATA = 2'd1;
    localparam logic [1:0] REQ_FCS = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef enum logic
    {
        ST_IDLE,
        ST_SEND
    } state_t;

    // Inputs of the shared line-bit step unit
    typedef struct packed
    {
        logic                line;
        logic [RunWidth-1:0] ones;
        logic [CrcWidth-1:0] crc;
        logic                bit_val;
        logic                crc_en;
    } step_in_t;

    // Outputs of the shared line-bit step unit
    typedef struct packed
    {
        logic                line;
        logic [RunWidth-1:0] ones;
        logic [CrcWidth-1:0] crc;
    } step_out_t;

endpackage

[hdl/hdlc_tx_stuff_nrzi_fcs_unit.sv]
// Top level of the serial HDLC transmitter with zero stuffing, NRZI and CRC-16 FCS.
//
// Each accepted item is a flag (req_type 0), a data byte (1) or an FCS request (2);
// code 3 is taken and dropped without effect. The block then sends one line bit per
// clock on the output channel, as long as the output is not stalled, and holds
// in_stall high until the item's final bit (flagged by last) has been produced. The
// single bit-step unit computes the NRZI level, the ones-run count and one CRC bit
// per line bit. Data bytes go out LSB first with a stuffing zero after five ones;
// the run carries across items, so a stuffing zero owed by the previous item is
// sent at the start of the next one. A flag sends 0x7E unstuffed and reloads the
// CRC from crc_init; the FCS is the complemented CRC, low byte first. crc_init is
// written through crc_init_we and crc_init_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce. It resets
// to 0xFFFF.
module hdlc_tx_stuff_nrzi_fcs_unit
    import hdlctx_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 crc_init_we,
    input  logic [CrcWidth-1:0]  crc_init_wdata,
    // input items
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           req_type,
    input  logic [ByteWidth-1:0] data_byte,
    // output items, one per line bit
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 line_level,
    output logic                 stuffed_bit,
    output logic                 last
);

    state_t state_reg, state_next;

    logic [CrcWidth-1:0]   crc_init_reg;
    logic [CrcWidth-1:0]   crc_reg;
    logic                  line_reg;
    logic [RunWidth-1:0]   ones_reg;
    logic                  prev_flag_reg;

    // Bit sequencer for the item in progress
    logic [CrcWidth-1:0]   shift_reg;
    logic [CountWidth-1:0] cnt_reg;
    logic                  pend_reg;
    logic                  stuff_en_reg;
    logic                  crc_en_reg;
    logic                  is_flag_reg;

    // Output register
    logic                  out_valid_reg;
    logic                  out_line_reg;
    logic                  out_stuff_reg;
    logic                  out_last_reg;

    logic      in_accept;
    logic      start_item;
    logic      out_free;
    logic      do_bit;
    logic      stuff_now;
    logic      bit_last;
    step_in_t  step_in;
    step_out_t step_out;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign start_item = in_accept && (req_type != REQ_NONE);

    assign out_valid = out_valid_reg;
    assign line_level = out_line_reg;
    assign stuffed_bit = out_stuff_reg;
    assign last = out_last_reg;

    // Produce a bit whenever the output register is empty or being drained
    assign out_free = !out_valid_reg || !out_stall;
    assign do_bit = (state_reg == ST_SEND) && out_free;

    // Stuff either the zero owed by the previous item or one due inside this item
    assign stuff_now = pend_reg || (stuff_en_reg && (ones_reg == STUFF_RUN));
    assign bit_last = !stuff_now && (cnt_reg == CountWidth'(1));

    always_comb
    begin
        step_in.line = line_reg;
        step_in.ones = ones_reg;
        step_in.crc = crc_reg;
        step_in.bit_val = stuff_now ? 1'b0 : shift_reg[0];
        step_in.crc_en = crc_en_reg && !stuff_now;
    end

    hdlctx_bit_step u_step
    (
        .step_in  (step_in),
        .step_out (step_out)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_item)
                begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (do_bit && bit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_init_reg <= CRC_INIT_RESET;
        end
        else if (crc_init_we)
        begin
            crc_init_reg <= crc_init_wdata;
        end
    end

    // Line state, CRC and item sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT_RESET;
            line_reg <= 1'b0;
            ones_reg <= '0;
            prev_flag_reg <= 1'b0;
            pend_reg <= 1'b0;
            stuff_en_reg <= 1'b0;
            crc_en_reg <= 1'b0;
            is_flag_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start_item)
        begin
            pend_reg <= !prev_flag_reg && (ones_reg == STUFF_RUN);
            case (req_type)
                REQ_FLAG:
                begin
                    cnt_reg <= BYTE_BITS;
                    stuff_en_reg <= 1'b0;
                    crc_en_reg <= 1'b0;
                    is_flag_reg <= 1'b1;
                    // A flag restarts the run count
                    ones_reg <= '0;
                end
                REQ_DATA:
                begin
                    cnt_reg <= BYTE_BITS;
                    stuff_en_reg <= 1'b1;
                    crc_en_reg <= 1'b1;
                    is_flag_reg <= 1'b0;
                end
                default:
                begin
                    cnt_reg <= FCS_BITS;
                    stuff_en_reg <= 1'b1;
                    crc_en_reg <= 1'b0;
                    is_flag_reg <= 1'b0;
                end
            endcase
        end
        else if (do_bit)
        begin
            line_reg <= step_out.line;
            ones_reg <= step_out.ones;
            crc_reg <= step_out.crc;
            if (stuff_now)
            begin
                pend_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - CountWidth'(1);
            end
            if (bit_last)
            begin
                prev_flag_reg <= is_flag_reg;
                if (is_flag_reg)
                begin
                    crc_reg <= crc_init_reg;
                end
            end
        end
    end

    // Bit shift register: payload only
    always_ff @(posedge clk)
    begin
        if (start_item)
        begin
            case (req_type)
                REQ_FLAG:
                begin
                    shift_reg <= {{(CrcWidth-ByteWidth){1'b0}}, FLAG_BYTE};
                end
                REQ_DATA:
                begin
                    shift_reg <= {{(CrcWidth-ByteWidth){1'b0}}, data_byte};
                end
                default:
                begin
                    shift_reg <= ~crc_reg;
                end
            endcase
        end
        else if (do_bit && !stuff_now)
        begin
            shift_reg <= {1'b0, shift_reg[CrcWidth-1:1]};
        end
    end

    // Output register: load a new bit, or drop the one just taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (do_bit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_bit)
        begin
            out_line_reg <= step_out.line;
            out_stuff_reg <= stuff_now;
            out_last_reg <= bit_last;
        end
    end

endmodule

[hdl/hdlctx_bit_step.sv]
// Shared per-bit unit: NRZI level, ones-run count and one CRC-16 bit step.
module hdlctx_bit_step
    import hdlctx_pkg::*;
(
    input  step_in_t  step_in,
    output step_out_t step_out
);

    logic                feedback;
    logic [CrcWidth-1:0] crc_shifted;

    assign feedback = step_in.crc[0] ^ step_in.bit_val;
    assign crc_shifted = {1'b0, step_in.crc[CrcWidth-1:1]} ^ (feedback ? CRC_POLY : '0);

    always_comb
    begin
        if (step_in.bit_val)
        begin
            // A one keeps the level and extends the run
            step_out.line = step_in.line;
            step_out.ones = step_in.ones + RunWidth'(1);
        end
        else
        begin
            // A zero toggles the level and breaks the run
            step_out.line = ~step_in.line;
            step_out.ones = '0;
        end
        step_out.crc = step_in.crc_en ? crc_shifted : step_in.crc;
    end

endmodule

[hdl/hdlctx_checker.sv]
// Port-level checker for the HDLC transmitter, bound to the top level.
module hdlctx_checker
    import hdlctx_pkg::*;
(
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input logic [1:0]     req_type,
    input logic           out_valid,
    input logic           out_stall,
    input logic           line_level,
    input logic           stuffed_bit,
    input logic           last
);

    // Hold a stalled output bit
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(line_level)
            && $stable(stuffed_bit) && $stable(last))
        else $error("stalled output bit changed");

    // A stuffing zero is never the final bit of an item
    a_stuff_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stuffed_bit |-> !last)
        else $error("stuffing zero marked as last");

    // Once a real request is taken, check that the input is stalled after it
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type != REQ_NONE) |=> in_stall)
        else $error("input not stalled after accepting a request");

    // A dropped request code leaves the block ready
    a_none_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == REQ_NONE) |=> !in_stall)
        else $error("unused request code started an item");

endmodule

bind hdlc_tx_stuff_nrzi_fcs_unit hdlctx_checker u_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .line_level  (line_level),
    .stuffed_bit (stuffed_bit),
    .last        (last)
);
